/* src/rpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg: shared definitions for the reverse pair counter
// Field widths, store depth default, total saturation limit and the control
// group that travels with a query beat along the cell row.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Default store depth (number of cells in the row)
  localparam int MAX_ITEMS_DEF = 1024;

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 19;

  // Largest value that running_total carries; the total saturates here
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Control group of one query beat moving along the row
  typedef struct packed {
    logic valid;  // beat present in this slot
    logic store;  // value still has to be written into a free cell
    logic last;   // final element of the sequence
    logic ovf;    // sequence has exceeded the store
  } tok_ctrl_t;

endpackage

/* src/rpc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_cell: one compare cell of the row
// Holds one stored value. A passing query beat is compared against it while
// the cell is occupied, or writes its value into it at the first free cell.
// ----------------------------------------------------------------------------
module rpc_cell
  import rpc_pkg::*;
#(
  parameter int FW = 11,  // width of the occupancy countdown
  parameter int CW = 11   // width of the hit count
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  tok_ctrl_t          ctrl_i,
  input  logic [VALUE_W-1:0] val_i,
  input  logic [FW-1:0]      rem_i,
  input  logic [CW-1:0]      cnt_i,
  output tok_ctrl_t          ctrl_o,
  output logic [VALUE_W-1:0] val_o,
  output logic [FW-1:0]      rem_o,
  output logic [CW-1:0]      cnt_o
);

  logic [VALUE_W-1:0] stored;
  logic               occupied;
  logic               hit;
  logic               write_en;
  logic signed [VALUE_W:0] twice;
  logic signed [VALUE_W:0] stored_ext;
  tok_ctrl_t          ctrl_next;
  logic [FW-1:0]      rem_next;
  logic [CW-1:0]      cnt_next;

  // Compare on 33 bits so doubling never overflows
  assign twice      = $signed({val_i, 1'b0});
  assign stored_ext = $signed({stored[VALUE_W-1], stored});

  // Cells ahead of the fill point hold this sequence's values
  assign occupied = (rem_i != '0);
  assign hit      = ctrl_i.valid && occupied && (stored_ext > twice);
  assign write_en = ctrl_i.valid && !occupied && ctrl_i.store;

  always_comb begin
    ctrl_next = ctrl_i;
    if (write_en) begin
      ctrl_next.store = 1'b0;
    end
    rem_next = occupied ? (rem_i - FW'(1)) : rem_i;
    cnt_next = cnt_i + CW'(hit);
  end

  // Control slot
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o <= '0;
    end else if (advance) begin
      ctrl_o <= ctrl_next;
    end
  end

  // Payload of the beat and the stored value
  always_ff @(posedge clk) begin
    if (advance) begin
      val_o <= val_i;
      rem_o <= rem_next;
      cnt_o <= cnt_next;
      if (write_en) begin
        stored <= val_i;
      end
    end
  end

endmodule

/* src/rpc_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_accum: running total and output register
// Adds each beat's hit count to the saturating sequence total and holds the
// result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module rpc_accum
  import rpc_pkg::*;
#(
  parameter int CW = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  tok_ctrl_t          ctrl_i,
  input  logic [CW-1:0]      cnt_i,
  output logic               out_valid,
  output logic [TOTAL_W-1:0] running_total,
  output logic               overflow,
  output logic               done_res
);

  localparam int SW = ((CW > TOTAL_W) ? CW : TOTAL_W) + 1;

  logic [TOTAL_W-1:0] total;
  logic [SW-1:0]      sum;
  logic [TOTAL_W-1:0] sat;

  // Saturating add
  assign sum = SW'(total) + SW'(cnt_i);
  assign sat = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // Control: total and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctrl_i.valid;
      if (ctrl_i.valid) begin
        total <= ctrl_i.last ? '0 : sat;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance && ctrl_i.valid) begin
      running_total <= sat;
      overflow      <= ctrl_i.ovf;
      done_res      <= ctrl_i.last;
    end
  end

endmodule

/* src/reverse_pair_counter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reverse_pair_counter_core: streaming reverse pair counter
// Input beats carry a signed value and a last mark. Each beat yields one
// result beat with the pair total of the sequence so far, an overflow flag
// and done_res, which repeats the last mark.
// Each value enters a row of MAX_ITEMS compare cells as a query beat. The
// beat moves one cell per cycle while the row advances, counts stored values
// above twice its own, and drops its value into the first free cell. The
// result beat comes out of every cell register and then the output register.
// Throughput is one beat per cycle while no result beat stalls: a following
// beat reaches the write cell after the one before it, so it sees that value.
// Beyond MAX_ITEMS values per sequence the overflow flag rises and further
// values are compared but not stored. After a last beat the next sequence
// starts empty; stale cells are skipped by the occupancy countdown.
// Reset clears the fill count, total and all beat slots; no clearing pass.
// A stalled result beat holds in the output register and freezes the whole
// row; in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module reverse_pair_counter_core
  import rpc_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [TOTAL_W-1:0]        running_total,
  output logic                      overflow,
  output logic                      done_res
);

  localparam int FW = $clog2(MAX_ITEMS + 1);
  localparam int CW = FW;

  logic          advance;
  logic          accept;
  logic          full;
  logic [FW-1:0] fill_count;
  logic          ovf_seq;

  tok_ctrl_t          ctrl_w [0:MAX_ITEMS];
  logic [VALUE_W-1:0] val_w  [0:MAX_ITEMS];
  logic [FW-1:0]      rem_w  [0:MAX_ITEMS];
  logic [CW-1:0]      cnt_w  [0:MAX_ITEMS];

  // Row moves whenever the output register is free or being emptied
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign full     = (fill_count == FW'(MAX_ITEMS));

  // Launch slot feeding the first cell
  always_comb begin
    ctrl_w[0].valid = accept;
    ctrl_w[0].store = !full;
    ctrl_w[0].last  = last;
    ctrl_w[0].ovf   = ovf_seq || full;
    val_w[0]        = value;
    rem_w[0]        = fill_count;
    cnt_w[0]        = '0;
  end

  // Fill count and sticky overflow of the current sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      ovf_seq    <= 1'b0;
    end else if (accept) begin
      if (last) begin
        fill_count <= '0;
        ovf_seq    <= 1'b0;
      end else begin
        if (!full) begin
          fill_count <= fill_count + FW'(1);
        end
        ovf_seq <= ovf_seq || full;
      end
    end
  end

  // Row of compare cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rpc_cell #(
      .FW (FW),
      .CW (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .ctrl_i  (ctrl_w[i]),
      .val_i   (val_w[i]),
      .rem_i   (rem_w[i]),
      .cnt_i   (cnt_w[i]),
      .ctrl_o  (ctrl_w[i+1]),
      .val_o   (val_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .cnt_o   (cnt_w[i+1])
    );
  end

  // Total and result register at the end of the row
  rpc_accum #(
    .CW (CW)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .ctrl_i        (ctrl_w[MAX_ITEMS]),
    .cnt_i         (cnt_w[MAX_ITEMS]),
    .out_valid     (out_valid),
    .running_total (running_total),
    .overflow      (overflow),
    .done_res      (done_res)
  );

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(MAX_ITEMS))
    else $error("fill count beyond store depth");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last) |=> (fill_count == '0 && !ovf_seq))
    else $error("sequence state not cleared after last beat");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !last && full) |=> ovf_seq)
    else $error("overflow not raised on full store");

  a_out_ovf_done: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !last && ovf_seq) |=> (ovf_seq && fill_count == FW'(MAX_ITEMS)))
    else $error("overflow set without a full store");

endmodule

/* dv/tb_reverse_pair_counter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reverse_pair_counter_core: self-checking bench for the reverse pair counter
// Streams signed values in sequences closed by a last mark and predicts every
// result beat (running pair total, overflow, done) from its own copy of the
// stored history. A short directed run covers the extreme values, the strict
// compare at exactly twice the value, one-item sequences and back-to-back last
// marks. Random sequences follow, one of them longer than the store. Both
// sides idle and stall at random. A watchdog catches a hung pipeline.
// ----------------------------------------------------------------------------
module tb_reverse_pair_counter_core;
  import rpc_pkg::*;

  localparam int STORE_DEPTH    = MAX_ITEMS_DEF;
  localparam int RANDOM_BEATS   = 1925;
  // Pipeline latency plus the longest output stall and input gap, several times
  localparam int WATCHDOG_LIMIT = 4 * (STORE_DEPTH + 1) + 2000;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value;
  logic                      last;
  logic                      out_valid;
  logic                      out_stall;
  logic [TOTAL_W-1:0]        running_total;
  logic                      overflow;
  logic                      done_res;

  // Expected result beat
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               ovf;
    logic               done;
  } total_beat_t;

  // --------------------------------------------------------------------------
  // Pair count predictor and queue of totals still owed by the block
  // --------------------------------------------------------------------------
  class reverse_pair_board;
    logic [VALUE_W-1:0] seen_values[$];
    total_beat_t        totals_due[$];
    int                 pair_sum;
    bit                 store_full;
    int                 errors;
    int                 beats_in;
    int                 sequences;
    int                 ovf_sequences;
    int                 results_checked;
    int                 top_total;

    function new();
      pair_sum   = 0;
      store_full = 0;
      errors     = 0;
      beats_in   = 0;
      sequences  = 0;
      ovf_sequences   = 0;
      results_checked = 0;
      top_total  = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Count held values strictly above twice v (33-bit compare), then store v if there is room
    function void note_value(input logic [VALUE_W-1:0] v, input logic is_last);
      logic signed [VALUE_W:0] twice;
      logic signed [VALUE_W:0] held;
      int                      hits;
      total_beat_t             want;
      twice = {v, 1'b0};
      hits  = 0;
      foreach (seen_values[i]) begin
        held = {seen_values[i][VALUE_W-1], seen_values[i]};
        if (held > twice) hits++;
      end
      // total saturates at the output width
      if (pair_sum + hits > int'(TOTAL_MAX)) pair_sum = int'(TOTAL_MAX);
      else pair_sum = pair_sum + hits;
      if (seen_values.size() < STORE_DEPTH) seen_values.insert(seen_values.size(), v);
      else store_full = 1'b1;
      want.total = pair_sum[TOTAL_W-1:0];
      want.ovf   = store_full;
      want.done  = is_last;
      totals_due.insert(totals_due.size(), want);
      beats_in++;
      if (pair_sum > top_total) top_total = pair_sum;
      // end of sequence: start empty
      if (is_last) begin
        sequences++;
        if (store_full) ovf_sequences++;
        seen_values.delete();
        pair_sum   = 0;
        store_full = 1'b0;
      end
    endfunction

    task check_total(input logic [TOTAL_W-1:0] t, input logic o, input logic d);
      total_beat_t want;
      if (totals_due.size() == 0) begin
        report($sformatf("result beat with none expected (total %0d)", t));
      end else begin
        want = totals_due.pop_front();
        results_checked++;
        if (t !== want.total)
          report($sformatf("running_total %0d, expected %0d", t, want.total));
        if (o !== want.ovf)
          report($sformatf("overflow %0b, expected %0b", o, want.ovf));
        if (d !== want.done)
          report($sformatf("done_res %0b, expected %0b", d, want.done));
      end
    endtask
  endclass

  reverse_pair_board sb;

  reverse_pair_counter_core #(
    .MAX_ITEMS(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .running_total(running_total),
    .overflow(overflow),
    .done_res(done_res)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Monitor: feed the predictor on input beats, check output beats
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_value(value, last);
      if (out_valid && !out_stall) sb.check_total(running_total, overflow, done_res);
    end
  end

  // Watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Output stall: free stretches, short stalls, now and then a long one
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int free_left  = 0;
  int stall_pick;

  always @(posedge clk) begin
    if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall  <= 1'b0;
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) stall_left = $urandom_range(1, 3);
      else if (stall_pick < 95) stall_left = $urandom_range(4, 20);
      else stall_left = $urandom_range(60, 250);
      if ($urandom_range(0, 99) < 15) free_left = $urandom_range(100, 400);
      else free_left = $urandom_range(0, 12);
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] prev_value = '0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Mix of small values (dense pairs), full range, extremes and near-half hits
  function automatic logic [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    int                        k;
    k = $urandom_range(0, 9);
    if (k <= 3) begin
      v = $urandom_range(0, 40);
      v = v - 20;
    end else if (k <= 5) begin
      v = $urandom;
    end else if (k == 6) begin
      case ($urandom_range(0, 7))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h0000_0000;
        3: v = 32'hFFFF_FFFF;
        4: v = 32'h4000_0000;
        5: v = 32'hC000_0000;
        6: v = 32'h3FFF_FFFF;
        default: v = 32'hBFFF_FFFF;
      endcase
    end else if (k <= 8) begin
      // around half of the previous value: exercises the strict compare
      v = $signed(prev_value) >>> 1;
      v = v + $urandom_range(0, 2) - 1;
    end else begin
      v = $urandom;
      v = v >>> $urandom_range(1, 30);
    end
    return v;
  endfunction

  // Drive one beat, hold until accepted, then idle for a random gap unless no_gaps is set
  task automatic push_value(input logic [VALUE_W-1:0] v, input logic is_last,
                            input bit no_gaps);
    int gap;
    in_valid <= 1'b1;
    value    <= v;
    last     <= is_last;
    prev_value = v;
    do @(posedge clk); while (in_stall);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int  sent;
    int  len;
    int  long_at;
    bit  long_done;
    bit  no_gaps;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= '0;
    last      <= 1'b0;
    out_stall <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme values and the compare boundary around 2x
    push_value(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_value(32'h8000_0000, 1'b0, 1'b0);
    push_value(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_value(32'h0000_0000, 1'b0, 1'b0);
    push_value(32'h3FFF_FFFF, 1'b0, 1'b0);
    push_value(32'h4000_0000, 1'b0, 1'b0);
    push_value(32'hC000_0000, 1'b0, 1'b0);
    push_value(32'hBFFF_FFFF, 1'b0, 1'b0);
    push_value(32'h0000_0001, 1'b1, 1'b0);
    // single-beat sequence
    push_value(32'h0000_0005, 1'b1, 1'b0);
    // held value equal to twice the new one does not count
    push_value(32'h0000_0004, 1'b0, 1'b1);
    push_value(32'h0000_0002, 1'b0, 1'b1);
    push_value(32'h0000_0001, 1'b0, 1'b1);
    push_value(32'hFFFF_FFFD, 1'b1, 1'b1);
    // back-to-back last marks, alternating bit patterns
    push_value(32'h5555_5555, 1'b1, 1'b1);
    push_value(32'hAAAA_AAAA, 1'b1, 1'b1);
    push_value(32'hFFFF_FFFE, 1'b0, 1'b0);
    push_value(32'h8000_0001, 1'b1, 1'b0);

    // Random sequences, mostly short, one past the store capacity
    sent      = 0;
    long_done = 1'b0;
    long_at   = $urandom_range(100, 600);
    while (sent < RANDOM_BEATS) begin
      if (!long_done && sent >= long_at) begin
        len       = STORE_DEPTH + $urandom_range(1, 60);
        long_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(41, 120);
      end else begin
        len = $urandom_range(1, 40);
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        push_value(pick_value(), k == len - 1, no_gaps);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray beats over one pipeline length
    while (sb.totals_due.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 8) @(posedge clk);

    $display("Run covered %0d beats in %0d sequences (%0d past store capacity).",
             sb.beats_in, sb.sequences, sb.ovf_sequences);
    $display("Checked %0d result beats, largest total %0d.",
             sb.results_checked, sb.top_total);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rpc_pkg.sv
src/rpc_cell.sv
src/rpc_accum.sv
src/reverse_pair_counter_core.sv
dv/tb_reverse_pair_counter_core.sv
